>>> hw/rtl/rbst_pkg.sv
// Shared types and constants for the ray/box slab test unit.
package rbst_pkg;

    localparam int Q_W           = 32;
    localparam int THR_W         = 17;
    localparam int MAX_AXES      = 3;
    localparam int FIELD_COUNT   = 12;
    localparam int IN_DATA_W     = FIELD_COUNT * Q_W;
    localparam int OUT_DATA_W    = 64;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_AXES      = 3;

    localparam logic signed [Q_W-1:0] Q_INF = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [THR_W-1:0] THR_RESET  = THR_W'(1);

    // Per-lane side information that travels alongside the dividers
    typedef struct packed {
        logic neg_lo;
        logic neg_hi;
        logic parallel;
        logic par_miss;
    } rbst_tag_t;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic                  miss;
        logic signed [Q_W-1:0] t_lo;
        logic signed [Q_W-1:0] t_hi;
    } rbst_lane_res_t;

endpackage

>>> hw/rtl/rbst_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rbst_div
    import rbst_pkg::*;
#(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] num_reg [1:NUM_W-1];
    logic [DEN_W-1:0] den_reg [1:NUM_W-1];
    logic [DEN_W-1:0] rem_reg [1:NUM_W-1];
    logic [NUM_W-1:0] quo_reg [1:NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_head
            assign num_in = num;
            assign den_in = den;
            assign rem_in = '0;
            assign quo_in = '0;
        end
        else
        begin : g_body
            assign num_in = num_reg[k];
            assign den_in = den_reg[k];
            assign rem_in = rem_reg[k];
            assign quo_in = quo_reg[k];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = !diff[DEN_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1] <= {quo_in[NUM_W-2:0], ge};
            end
        end

        // the last stage only delivers the quotient
        if (k < NUM_W-1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    num_reg[k+1] <= {num_in[NUM_W-2:0], 1'b0};
                    den_reg[k+1] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[NUM_W];

endmodule

>>> hw/rtl/rbst_lane.sv
// One axis lane: slab setup, two slab-distance dividers, saturation and ordering.
module rbst_lane
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic signed [Q_W-1:0] origin,
    input  logic signed [Q_W-1:0] dir,
    input  logic signed [Q_W-1:0] box_min,
    input  logic signed [Q_W-1:0] box_max,
    input  logic [THR_W-1:0]      threshold,
    output rbst_lane_res_t        res
);

    localparam int DIFF_W = Q_W + 1;
    localparam int NUM_W  = DIFF_W + FRAC_BITS;

    logic signed [DIFF_W-1:0] diff_lo, diff_hi;
    logic [DIFF_W-1:0]        mag_lo, mag_hi;
    logic [Q_W-1:0]           dir_mag;
    logic                     is_par;

    assign diff_lo = DIFF_W'(box_min) - DIFF_W'(origin);
    assign diff_hi = DIFF_W'(box_max) - DIFF_W'(origin);
    assign mag_lo  = diff_lo[DIFF_W-1] ? DIFF_W'(-diff_lo) : DIFF_W'(diff_lo);
    assign mag_hi  = diff_hi[DIFF_W-1] ? DIFF_W'(-diff_hi) : DIFF_W'(diff_hi);
    assign dir_mag = dir[Q_W-1] ? Q_W'(-dir) : Q_W'(dir);
    assign is_par  = (dir == '0) || (dir_mag < Q_W'(threshold));

    logic [NUM_W-1:0] num_lo_reg, num_hi_reg;
    logic [Q_W-1:0]   den_reg;
    rbst_tag_t        tag_reg [0:NUM_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_lo_reg        <= {mag_lo, {FRAC_BITS{1'b0}}};
            num_hi_reg        <= {mag_hi, {FRAC_BITS{1'b0}}};
            den_reg           <= dir_mag;
            tag_reg[0].neg_lo <= diff_lo[DIFF_W-1] ^ dir[Q_W-1];
            tag_reg[0].neg_hi <= diff_hi[DIFF_W-1] ^ dir[Q_W-1];
            tag_reg[0].parallel <= is_par;
            tag_reg[0].par_miss <= is_par && ((origin < box_min) || (origin > box_max));
        end
    end

    // hold side information in step with the divider stages
    for (genvar k = 0; k < NUM_W; k++) begin : g_tag
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    logic [NUM_W-1:0] quo_lo, quo_hi;

    rbst_div #(.NUM_W(NUM_W), .DEN_W(Q_W)) u_div_lo (
        .clk (clk),
        .en  (en),
        .num (num_lo_reg),
        .den (den_reg),
        .quo (quo_lo)
    );

    rbst_div #(.NUM_W(NUM_W), .DEN_W(Q_W)) u_div_hi (
        .clk (clk),
        .en  (en),
        .num (num_hi_reg),
        .den (den_reg),
        .quo (quo_hi)
    );

    function automatic logic signed [Q_W-1:0] sat_q(input logic neg,
                                                    input logic [NUM_W-1:0] mag);
        logic pos_ovf;
        logic neg_ovf;
        pos_ovf = |mag[NUM_W-1:Q_W-1];
        neg_ovf = (|mag[NUM_W-1:Q_W]) || (mag[Q_W-1] && (|mag[Q_W-2:0]));
        if (neg)
            sat_q = neg_ovf ? Q_MIN : -$signed(mag[Q_W-1:0]);
        else
            sat_q = pos_ovf ? Q_INF : $signed({1'b0, mag[Q_W-2:0]});
    endfunction

    rbst_tag_t             tag_out;
    logic signed [Q_W-1:0] t1, t2;

    assign tag_out = tag_reg[NUM_W];
    assign t1      = sat_q(tag_out.neg_lo, quo_lo);
    assign t2      = sat_q(tag_out.neg_hi, quo_hi);

    rbst_lane_res_t res_reg;

    // a parallel slab leaves the interval alone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (en)
        begin
            res_reg.miss <= tag_out.par_miss;
            if (tag_out.parallel)
            begin
                res_reg.t_lo <= '0;
                res_reg.t_hi <= Q_INF;
            end
            else if (t1 > t2)
            begin
                res_reg.t_lo <= t2;
                res_reg.t_hi <= t1;
            end
            else
            begin
                res_reg.t_lo <= t1;
                res_reg.t_hi <= t2;
            end
        end
    end

    assign res = res_reg;

endmodule

>>> hw/rtl/rbst_merge.sv
// Combine the lane intervals into the hit flag and the entry/exit distances.
module rbst_merge
    import rbst_pkg::*;
#(
    parameter int AXES = DEF_AXES
)
(
    input  rbst_lane_res_t lanes [0:AXES-1],
    output logic           hit,
    output logic [Q_W-2:0] t_near,
    output logic [Q_W-2:0] t_far
);

    logic signed [Q_W-1:0] near_v, far_v;
    logic                  any_miss;

    always_comb
    begin
        near_v   = '0;
        far_v    = Q_INF;
        any_miss = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            any_miss = any_miss | lanes[a].miss;
            if (lanes[a].t_lo > near_v)
                near_v = lanes[a].t_lo;
            if (lanes[a].t_hi < far_v)
                far_v = lanes[a].t_hi;
        end
    end

    assign hit    = !any_miss && (near_v <= far_v);
    assign t_near = hit ? near_v[Q_W-2:0] : '0;
    assign t_far  = hit ? far_v[Q_W-2:0] : '0;

endmodule

>>> hw/rtl/ray_box_slab_test_unit.sv
// Top level of the ray versus axis-aligned box slab test unit.
//
// One ray/box transaction is accepted every cycle while the pipeline advances,
// and its result passes through the input register, one divider stage per
// quotient bit of the 33 + FRAC_BITS bit numerator, the lane result register
// and the output register. Each axis has its own lane with two pipelined
// dividers; a merge stage forms the hit flag and the interval. The whole
// pipeline advances whenever the output register is empty or being taken, so
// a stall on the master side holds every stage. The threshold register may be
// written only while no transaction is in flight.
module ray_box_slab_test_unit
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int AXES      = DEF_AXES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z (32 bits each)
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit [0], t_near [31:1], t_far [62:32], zero [63]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int LAT = FRAC_BITS + Q_W + 3;

    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    logic en;
    logic out_valid_reg;
    logic [LAT-1:0] vld_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    rbst_lane_res_t lanes [0:AXES-1];

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .origin    (s_axis_tdata[a*Q_W +: Q_W]),
            .dir       (s_axis_tdata[(MAX_AXES+a)*Q_W +: Q_W]),
            .box_min   (s_axis_tdata[(2*MAX_AXES+a)*Q_W +: Q_W]),
            .box_max   (s_axis_tdata[(3*MAX_AXES+a)*Q_W +: Q_W]),
            .threshold (thr_reg),
            .res       (lanes[a])
        );
    end

    logic           hit;
    logic [Q_W-2:0] t_near, t_far;

    rbst_merge #(.AXES(AXES)) u_merge (
        .lanes  (lanes),
        .hit    (hit),
        .t_near (t_near),
        .t_far  (t_far)
    );

    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {1'b0, t_far, t_near, hit};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> verif/ray_box_slab_test_unit_test.sv
// Self-checking testbench for the ray/box slab test unit.
module ray_box_slab_test_unit_test;
    import rbst_pkg::*;

    localparam int LATENCY     = DEF_FRAC_BITS + 36;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1150;

    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        q_t max_z, max_y, max_x;
        q_t min_z, min_y, min_x;
        q_t dir_z, dir_y, dir_x;
        q_t org_z, org_y, org_x;
    } ray_box_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] t_near;
        logic [30:0] t_far;
    } slab_res_t;

    // directed row: item, optional expected result typed in by hand
    typedef struct {
        ray_box_t  item;
        bit        has_exp;
        slab_res_t exp_res;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [THR_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [THR_W-1:0] par_thresh;
    slab_res_t        expected_q[$];
    int               n_errors = 0;
    int               n_results = 0;
    int               n_hits = 0;
    int               n_cycles = 0;
    bit               hold_off = 1'b0;
    bit               stall_free = 1'b0;

    always #2 clk = ~clk;

    ray_box_slab_test_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic longint slab_dist(longint bound, longint org, longint dir);
        longint q;
        q = ((bound - org) * 65536) / dir;
        if (q > 64'sh7FFFFFFF)
            q = 64'sh7FFFFFFF;
        if (q < -64'sh80000000)
            q = -64'sh80000000;
        return q;
    endfunction

    function automatic slab_res_t predict_slab(ray_box_t rb);
        longint    o[3], d[3], lo[3], hi[3];
        longint    t_in, t_out, t1, t2, t_swap, mag;
        slab_res_t r;
        bit        hit;
        o = '{rb.org_x, rb.org_y, rb.org_z};
        d = '{rb.dir_x, rb.dir_y, rb.dir_z};
        lo = '{rb.min_x, rb.min_y, rb.min_z};
        hi = '{rb.max_x, rb.max_y, rb.max_z};
        t_in = 0;
        t_out = 64'sh7FFFFFFF;
        hit = 1'b1;
        for (int a = 0; a < DEF_AXES; a++)
        begin
            mag = d[a] < 0 ? -d[a] : d[a];
            if (d[a] == 0 || mag < longint'(par_thresh))
            begin
                if (o[a] < lo[a] || o[a] > hi[a])
                begin
                    hit = 1'b0;
                    break;
                end
            end
            else
            begin
                t1 = slab_dist(lo[a], o[a], d[a]);
                t2 = slab_dist(hi[a], o[a], d[a]);
                if (t1 > t2)
                begin
                    t_swap = t1;
                    t1 = t2;
                    t2 = t_swap;
                end
                if (t1 > t_in)
                    t_in = t1;
                if (t2 < t_out)
                    t_out = t2;
                if (t_in > t_out)
                begin
                    hit = 1'b0;
                    break;
                end
            end
        end
        r.hit = hit;
        r.t_near = hit ? t_in[30:0] : '0;
        r.t_far = hit ? t_out[30:0] : '0;
        return r;
    endfunction

    function automatic q_t rand_q(int mode);
        case (mode)
            0: return q_t'($urandom);
            1: return q_t'($urandom_range(0, 20 * 65536)) - q_t'(10 * 65536);
            2: return q_t'($urandom_range(0, 4)) - q_t'(2);
            default:
                return ($urandom_range(0, 1) ? Q_INF : Q_MIN) - q_t'($urandom_range(0, 3));
        endcase
    endfunction

    // mostly sane rays and boxes near the origin; some noise, extremes and inverted boxes
    function automatic ray_box_t rand_ray_box();
        ray_box_t rb;
        int       kind;
        q_t       a, b;
        kind = $urandom_range(0, 9);
        rb.org_x = rand_q(kind == 0 ? 0 : (kind == 1 ? 3 : 1));
        rb.org_y = rand_q(kind == 0 ? 0 : 1);
        rb.org_z = rand_q(kind == 0 ? 0 : 1);
        rb.dir_x = rand_q(kind < 2 ? 0 : ($urandom_range(0, 7) == 0 ? 2 : 1));
        rb.dir_y = rand_q(kind < 2 ? 0 : ($urandom_range(0, 7) == 0 ? 2 : 1));
        rb.dir_z = rand_q(kind == 0 ? 3 : ($urandom_range(0, 7) == 0 ? 2 : 1));
        for (int i = 0; i < 3; i++)
        begin
            a = rand_q(kind == 0 ? 0 : 1);
            b = rand_q(kind == 0 ? 0 : 1);
            if (kind != 9 && a > b)
            begin
                q_t t;
                t = a;
                a = b;
                b = t;
            end
            case (i)
                0: begin rb.min_x = a; rb.max_x = b; end
                1: begin rb.min_y = a; rb.max_y = b; end
                default: begin rb.min_z = a; rb.max_z = b; end
            endcase
        end
        return rb;
    endfunction

    function automatic ray_box_t mk(q_t ox, q_t oy, q_t oz, q_t dx, q_t dy, q_t dz,
                                     q_t lx, q_t ly, q_t lz, q_t hx, q_t hy, q_t hz);
        ray_box_t rb;
        rb = '{hz, hy, hx, lz, ly, lx, dz, dy, dx, oz, oy, ox};
        return rb;
    endfunction

    function automatic q_t Q_MAX_F();
        return Q_INF - q_t'(65536);
    endfunction

    task automatic send_ray_box(ray_box_t rb);
        // random gap before some items; bursts otherwise
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rb;
        expected_q.push_back(predict_slab(rb));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_checked(ray_box_t rb, bit has_exp, slab_res_t e);
        if (has_exp && predict_slab(rb) !== e)
        begin
            $display("%0t directed row disagrees with prediction: exp %h pred %h",
                     $time, e, predict_slab(rb));
            n_errors++;
        end
        send_ray_box(rb);
    endtask

    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_thresh(logic [THR_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        par_thresh = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: its own stall pattern, a stall-free phase, plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (stall_free)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge clk)
    begin
        slab_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[0], m_axis_tdata[31:1], m_axis_tdata[62:32]};
            n_results++;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                n_errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                n_hits += want.hit;
                if (got.hit !== want.hit)
                begin
                    $display("%0t hit: exp %0b got %0b", $time, want.hit, got.hit);
                    n_errors++;
                end
                if (got.t_near !== want.t_near)
                begin
                    $display("%0t t_near: exp %h got %h", $time, want.t_near, got.t_near);
                    n_errors++;
                end
                if (got.t_far !== want.t_far)
                begin
                    $display("%0t t_far: exp %h got %h", $time, want.t_far, got.t_far);
                    n_errors++;
                end
            end
            if (m_axis_tdata[63] !== 1'b0)
            begin
                $display("%0t spare bit: exp 0 got %b", $time, m_axis_tdata[63]);
                n_errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        slab_res_t miss_res;
        slab_res_t full_res;
        q_t one;
        one = q_t'(65536);
        miss_res = '0;
        full_res = '{1'b1, 31'd0, 31'h7FFFFFFF};
        par_thresh = THR_RESET;
        // origin inside box, all directions zero: whole interval
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, -one, -one, -one, one, one, one), 1, full_res});
        // parallel outside on x, y, z
        rows.push_back('{mk(2 * one, 0, 0, 0, one, one, -one, -one, -one, one, one, one),
                         1, miss_res});
        rows.push_back('{mk(0, -2 * one, 0, one, 0, one, -one, -one, -one, one, one, one),
                         1, miss_res});
        rows.push_back('{mk(0, 0, 2 * one, one, one, 0, -one, -one, -one, one, one, one),
                         1, miss_res});
        // plain hit along +x
        rows.push_back('{mk(-4 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one),
                         1, '{1'b1, 31'(3 * 65536), 31'(5 * 65536)}});
        // negative direction
        rows.push_back('{mk(4 * one, 0, 0, -one, 0, 0, -one, -one, -one, one, one, one),
                         1, '{1'b1, 31'(3 * 65536), 31'(5 * 65536)}});
        // box behind the ray: empty interval
        rows.push_back('{mk(4 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one),
                         1, miss_res});
        // inverted box
        rows.push_back('{mk(0, 0, 0, one, one, one, one, one, one, -one, -one, -one), 0, '0});
        // extremes with saturation
        rows.push_back('{mk(Q_MIN, Q_MIN, Q_MIN, 1, 1, 1, Q_MAX_F(), Q_MAX_F(), Q_MAX_F(),
                            Q_INF, Q_INF, Q_INF), 0, '0});
        rows.push_back('{mk(Q_INF, Q_INF, Q_INF, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                            Q_INF, Q_INF, Q_INF), 0, '0});
        rows.push_back('{mk(Q_MIN, 0, 0, -1, 1, -1, Q_MIN, Q_MIN, Q_MIN,
                            Q_INF, Q_INF, Q_INF), 0, '0});
        rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 0, '0});
        rows.push_back('{mk(0, 0, 0, one, one, one, 0, 0, 0, 0, 0, 0), 0, '0});
        // threshold border: direction 1 with reset threshold 1 is not parallel
        rows.push_back('{mk(0, 0, 0, 1, -1, 1, -one, -one, -one, one, one, one), 0, '0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_checked(rows[i].item, rows[i].has_exp, rows[i].exp_res);
        drain_and_idle();

        // several threshold settings, extremes among them
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_thresh('0);
                1: write_thresh(17'h10000);
                2: write_thresh(17'd1);
                3: write_thresh(17'(~0 >> 0));
                default: write_thresh(17'($urandom_range(0, 65536)));
            endcase
            if (ph == 1)
            begin
                // long hold-off: the block fills up and stalls its input
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (LATENCY * 3) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            stall_free = (ph == 2);
            for (int n = 0; n < N_RANDOM / 5; n++)
                send_ray_box(rand_ray_box());
            drain_and_idle();
        end

        $display("Checked %0d results (%0d hits) over %0d directed and %0d random rays.",
                 n_results, n_hits, rows.size(), N_RANDOM);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_div.sv
hw/rtl/rbst_lane.sv
hw/rtl/rbst_merge.sv
hw/rtl/ray_box_slab_test_unit.sv
verif/ray_box_slab_test_unit_test.sv
